// ----- hdl/pqc_pkg.sv -----
// ---------------------------------------------------------------------------
// Pulse counter package
// Shared constants, operation codes and structures of the four-channel
// pulse counter with period measurement.
// ---------------------------------------------------------------------------
package pqc_pkg;

  // Number of counting lanes; lanes from PIN_W upwards have no pin.
  localparam int CHANNELS = 4;
  localparam int PIN_W    = 4;

  // Field widths of the input and result words.
  localparam int OP_W     = 2;
  localparam int CH_W     = 2;
  localparam int COUNT_W  = 32;
  localparam int TIME_W   = 32;
  localparam int PERIOD_W = 20;

  // Largest period that is reported.
  localparam logic [TIME_W-1:0] PERIOD_MAX = TIME_W'(999999);

  // Operation codes of the input word.
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // Per-lane controls decoded from one accepted input word.
  typedef struct packed {
    logic sample;
    logic level;
    logic read;
  } lane_ctl_t;

  // What one lane reports when it is read.
  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [PERIOD_W-1:0] period;
  } lane_res_t;

  // One result word as it is held in the output stage.
  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [COUNT_W-1:0]  count;
    logic [PERIOD_W-1:0] period;
  } result_t;

endpackage

// ----- hdl/pqc_in_if.sv -----
// ---------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one input word: opcode, pin levels, channel.
// ---------------------------------------------------------------------------
interface pqc_in_if;
  logic                        valid;
  logic                        ready;
  logic [pqc_pkg::OP_W-1:0]    opcode;
  logic [pqc_pkg::PIN_W-1:0]   pin_levels;
  logic [pqc_pkg::CH_W-1:0]    channel;

  modport source (output valid, output opcode, output pin_levels, output channel,
                  input ready);
  modport sink   (input valid, input opcode, input pin_levels, input channel,
                  output ready);
endinterface

// ----- hdl/pqc_out_if.sv -----
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result word: channel, count and period.
// ---------------------------------------------------------------------------
interface pqc_out_if;
  logic                          valid;
  logic                          ready;
  logic [pqc_pkg::CH_W-1:0]      channel_out;
  logic [pqc_pkg::COUNT_W-1:0]   pulse_count;
  logic [pqc_pkg::PERIOD_W-1:0]  pulse_period_ms;

  modport source (output valid, output channel_out, output pulse_count,
                  output pulse_period_ms, input ready);
  modport sink   (input valid, input channel_out, input pulse_count,
                  input pulse_period_ms, output ready);
endinterface

// ----- hdl/pqc_lane.sv -----
// ---------------------------------------------------------------------------
// Counting lane
// Edge detector, edge counter and period store of one channel.
// ---------------------------------------------------------------------------
module pqc_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pqc_pkg::lane_ctl_t            ctl,
  input  logic [pqc_pkg::TIME_W-1:0]    now_ms,
  output pqc_pkg::lane_res_t            res
);

  logic                          last_level_r;
  logic [pqc_pkg::COUNT_W-1:0]   count_r;
  logic [pqc_pkg::TIME_W-1:0]    period_r;
  logic [pqc_pkg::TIME_W-1:0]    edge_time_r;

  logic                          fall;
  logic [pqc_pkg::TIME_W-1:0]    elapsed;
  logic [pqc_pkg::TIME_W-1:0]    raised;
  logic [pqc_pkg::TIME_W-1:0]    period_sat;

  // A falling edge is a high level in the previous sample and low now.
  assign fall = ctl.sample && last_level_r && !ctl.level;

  // Period on a read: raised to the time since the last edge, then saturated.
  assign elapsed    = now_ms - edge_time_r;
  assign raised     = (elapsed > period_r) ? elapsed : period_r;
  assign period_sat = (raised > pqc_pkg::PERIOD_MAX) ? pqc_pkg::PERIOD_MAX : raised;

  assign res.count  = count_r;
  assign res.period = period_sat[pqc_pkg::PERIOD_W-1:0];

  // Lane state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r <= 1'b0;
      count_r      <= '0;
      period_r     <= '0;
      edge_time_r  <= '0;
    end else begin
      if (ctl.sample) begin
        last_level_r <= ctl.level;
      end
      if (fall) begin
        count_r     <= count_r + 1'b1;
        period_r    <= elapsed;
        edge_time_r <= now_ms;
      end else if (ctl.read) begin
        count_r  <= '0;
        period_r <= period_sat;
      end
    end
  end

  // A read leaves the count cleared.
  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.read && !ctl.sample |=> count_r == '0)
    else $error("lane count not cleared after read");

  // A read leaves a period that is within the reported range.
  a_read_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.read && !ctl.sample |=> period_r <= pqc_pkg::PERIOD_MAX)
    else $error("lane period above limit after read");

  // An edge records the clock value of its sample.
  a_edge_time: assert property (@(posedge clk) disable iff (!rst_n)
    fall |=> edge_time_r == $past(now_ms))
    else $error("lane edge time not recorded");

endmodule

// ----- hdl/pqc_merge.sv -----
// ---------------------------------------------------------------------------
// Result merge
// Picks the result of the lane that was read and holds it in an output
// register backed by a skid register.
// ---------------------------------------------------------------------------
module pqc_merge (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [pqc_pkg::CHANNELS-1:0]     sel,
  input  logic [pqc_pkg::CH_W-1:0]         channel,
  input  pqc_pkg::lane_res_t               lane_res [pqc_pkg::CHANNELS],
  output logic                             in_ready,
  output logic                             out_valid,
  input  logic                             out_ready,
  output pqc_pkg::result_t                 out_word
);

  pqc_pkg::lane_res_t   picked;
  pqc_pkg::result_t     new_word;
  logic                 push;
  logic                 pop;

  logic                 out_v_r;
  logic                 skid_v_r;
  pqc_pkg::result_t     out_r;
  pqc_pkg::result_t     skid_r;

  // At most one lane is selected, so an OR over masked results picks it.
  always_comb begin
    picked = '0;
    for (int n = 0; n < pqc_pkg::CHANNELS; n++) begin
      if (sel[n]) begin
        picked = picked | lane_res[n];
      end
    end
  end

  assign push             = |sel;
  assign new_word.channel = channel;
  assign new_word.count   = picked.count;
  assign new_word.period  = picked.period;

  assign pop       = out_v_r && out_ready;
  assign in_ready  = !skid_v_r;
  assign out_valid = out_v_r;
  assign out_word  = out_r;

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || pop) begin
      if (skid_v_r) begin
        out_r    <= skid_r;
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_r   <= new_word;
        out_v_r <= push;
      end
    end else if (push) begin
      skid_r   <= new_word;
      skid_v_r <= 1'b1;
    end
  end

  // The skid register is only in use behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid word held while output register is empty");

  // A result never arrives while the skid register is full.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> !push)
    else $error("result word lost on a full skid register");

  // An empty output register never fills the skid register.
  a_empty_no_skid: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |=> !skid_v_r)
    else $error("skid register filled past an empty output register");

endmodule

// ----- hdl/quad_pulse_counter_with_period_core.sv -----
// ---------------------------------------------------------------------------
// Four-channel pulse counter with period measurement
// Counts falling edges per channel, measures pulse periods in milliseconds
// and returns one channel's count and period on a read word.
// ---------------------------------------------------------------------------
// Each input word, a pin sample, a millisecond tick or a read, is applied to
// all counting lanes in parallel at the edge where it is accepted, so a new
// word may be accepted in every cycle while input ready is high. A read
// result is registered in the output register, or in the skid register if
// the output register holds a result not yet taken, so input words keep
// flowing while one result waits; input ready falls only when two results
// are waiting. Unused channel numbers and the unused opcode give no result.
module quad_pulse_counter_with_period_core (
  input  logic       clk,
  input  logic       rst_n,
  pqc_in_if.sink     in_bus,
  pqc_out_if.source  out_bus
);

  logic                               accept;
  logic                               read_ok;
  logic [pqc_pkg::TIME_W-1:0]         now_ms_r;
  logic [pqc_pkg::CHANNELS-1:0]       sel;
  pqc_pkg::lane_ctl_t                 ctl [pqc_pkg::CHANNELS];
  pqc_pkg::lane_res_t                 lane_res [pqc_pkg::CHANNELS];
  pqc_pkg::result_t                   out_word;
  logic                               merge_ready;

  assign accept  = in_bus.valid && merge_ready;
  assign read_ok = accept && (in_bus.opcode == pqc_pkg::OP_READ)
                   && (32'(in_bus.channel) < pqc_pkg::CHANNELS);
  assign in_bus.ready = merge_ready;

  // Millisecond clock, advanced only by tick words.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_ms_r <= '0;
    end else if (accept && (in_bus.opcode == pqc_pkg::OP_TICK)) begin
      now_ms_r <= now_ms_r + 1'b1;
    end
  end

  // One counting lane per channel.
  for (genvar n = 0; n < pqc_pkg::CHANNELS; n++) begin : g_lane
    if (n < pqc_pkg::PIN_W) begin : g_pin
      assign ctl[n].level = in_bus.pin_levels[n];
    end else begin : g_nopin
      assign ctl[n].level = 1'b0;
    end
    assign ctl[n].sample = accept && (in_bus.opcode == pqc_pkg::OP_SAMPLE);
    assign sel[n]        = read_ok && (32'(in_bus.channel) == n);
    assign ctl[n].read   = sel[n];

    pqc_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl[n]),
      .now_ms (now_ms_r),
      .res    (lane_res[n])
    );
  end

  // Merge of the lane results into the output stage.
  pqc_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .sel       (sel),
    .channel   (in_bus.channel),
    .lane_res  (lane_res),
    .in_ready  (merge_ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_word  (out_word)
  );

  assign out_bus.channel_out     = out_word.channel;
  assign out_bus.pulse_count     = out_word.count;
  assign out_bus.pulse_period_ms = out_word.period;

endmodule

// ----- tb/quad_pulse_counter_with_period_core_test.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Pulse counter with period measurement: self-checking testbench
// Drives pin samples, millisecond ticks, reads and unused opcodes into the
// four-channel counter, predicts read results with a model of the counting
// lanes kept here or takes them from the directed table where a row gives them,
// and compares each result word field by field. A directed table runs first,
// followed by random traffic with random idling.
module quad_pulse_counter_with_period_core_test;

  // The fourth opcode has no meaning and must be ignored by the block.
  localparam logic [pqc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_WORDS = 2000;
  localparam int CALM_WORDS   = 300;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int PRINT_LIMIT  = 50;

  // One row of the directed stimulus table.
  typedef struct packed {
    logic [pqc_pkg::OP_W-1:0]  op;
    logic [pqc_pkg::PIN_W-1:0] pins;
    logic [pqc_pkg::CH_W-1:0]  ch;
    logic [31:0]               reps;
    logic                      typed;
    pqc_pkg::result_t          want;
  } step_t;

  logic clk = 1'b0;
  logic rst_n;

  pqc_in_if  in_bus ();
  pqc_out_if out_bus ();

  quad_pulse_counter_with_period_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // Predicted state of the counting lanes and the millisecond clock.
  logic                        lvl_seen  [pqc_pkg::CHANNELS];
  logic [pqc_pkg::COUNT_W-1:0] pulses    [pqc_pkg::CHANNELS];
  logic [pqc_pkg::TIME_W-1:0]  period_ms [pqc_pkg::CHANNELS];
  logic [pqc_pkg::TIME_W-1:0]  edge_at   [pqc_pkg::CHANNELS];
  logic [pqc_pkg::TIME_W-1:0]  clock_ms;

  pqc_pkg::result_t pending_readings [$];
  step_t   plan [$];
  int      mismatches = 0;
  int      cycles = 0;
  bit      calm = 1'b1;
  bit      src_idles = 1'b0;
  bit      sink_idles = 1'b0;
  int      stall_left = 0;

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Applies one accepted word to the predicted lanes; returns 1 for a reading.
  function automatic bit meter_apply(input logic [pqc_pkg::OP_W-1:0] op,
                                     input logic [pqc_pkg::PIN_W-1:0] pins,
                                     input logic [pqc_pkg::CH_W-1:0] ch,
                                     output pqc_pkg::result_t rd);
    logic                       lvl;
    logic [pqc_pkg::TIME_W-1:0] gap;
    logic [pqc_pkg::TIME_W-1:0] per;
    rd = '0;
    meter_apply = 1'b0;
    case (op)
      pqc_pkg::OP_SAMPLE: begin
        for (int n = 0; n < pqc_pkg::CHANNELS; n++) begin
          // Lanes without a pin always see a low level.
          lvl = (n < pqc_pkg::PIN_W) ? pins[n] : 1'b0;
          if (!lvl && lvl_seen[n]) begin
            pulses[n]    = pulses[n] + 1'b1;
            period_ms[n] = clock_ms - edge_at[n];
            edge_at[n]   = clock_ms;
          end
          lvl_seen[n] = lvl;
        end
      end
      pqc_pkg::OP_TICK: begin
        clock_ms = clock_ms + 1'b1;
      end
      pqc_pkg::OP_READ: begin
        if (int'(ch) < pqc_pkg::CHANNELS) begin
          // A long silence since the last edge raises the period; it is then clipped.
          gap = clock_ms - edge_at[ch];
          per = period_ms[ch];
          if (gap > per) per = gap;
          if (per > pqc_pkg::PERIOD_MAX) per = pqc_pkg::PERIOD_MAX;
          period_ms[ch] = per;
          rd.channel  = ch;
          rd.count    = pulses[ch];
          rd.period   = per[pqc_pkg::PERIOD_W-1:0];
          pulses[ch]  = '0;
          meter_apply = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // Counts a mismatch and prints one line for each of the first PRINT_LIMIT.
  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycles);
  endtask

  task automatic add_row(input logic [pqc_pkg::OP_W-1:0] op,
                         input logic [pqc_pkg::PIN_W-1:0] pins,
                         input logic [pqc_pkg::CH_W-1:0] ch, input int reps,
                         input bit typed, input int cnt, input int per);
    step_t s;
    s.op    = op;
    s.pins  = pins;
    s.ch    = ch;
    s.reps  = reps;
    s.typed = typed;
    s.want  = {ch, pqc_pkg::COUNT_W'(cnt), pqc_pkg::PERIOD_W'(per)};
    plan.push_back(s);
  endtask

  // Offers one word, waits for its acceptance and records the expected reading.
  task automatic send_word(input logic [pqc_pkg::OP_W-1:0] op,
                           input logic [pqc_pkg::PIN_W-1:0] pins,
                           input logic [pqc_pkg::CH_W-1:0] ch, input bit typed,
                           input pqc_pkg::result_t want);
    pqc_pkg::result_t rd;
    bit               has;
    if (!calm && src_idles && $urandom_range(0, 5) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.opcode     <= op;
    in_bus.pin_levels <= pins;
    in_bus.channel    <= ch;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    has = meter_apply(op, pins, ch, rd);
    if (has) pending_readings.push_back(typed ? want : rd);
  endtask

  // Result side: stalls in short bursts, switched on and off in stretches.
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) sink_idles = !sink_idles;
    if (!calm && sink_idles && stall_left == 0 && $urandom_range(0, 4) == 0)
      stall_left = $urandom_range(1, 3);
    if (stall_left > 0) begin
      out_bus.ready <= 1'b0;
      stall_left--;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // Checks each accepted result word against the oldest expected reading.
  always @(posedge clk) begin
    pqc_pkg::result_t want;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (pending_readings.size() == 0) begin
        flag_mismatch("result word with no reading pending", out_bus.pulse_count, 0);
      end else begin
        want = pending_readings.pop_front();
        if (out_bus.channel_out !== want.channel)
          flag_mismatch("channel_out", out_bus.channel_out, want.channel);
        if (out_bus.pulse_count !== want.count)
          flag_mismatch("pulse_count", out_bus.pulse_count, want.count);
        if (out_bus.pulse_period_ms !== want.period)
          flag_mismatch("pulse_period_ms", out_bus.pulse_period_ms, want.period);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** quad_pulse_counter_with_period_core: FAILED **");
      $finish;
    end
  end

  initial begin : main
    step_t s;
    int    pick;
    int    burst;
    in_bus.valid      <= 1'b0;
    in_bus.opcode     <= pqc_pkg::OP_SAMPLE;
    in_bus.pin_levels <= '0;
    in_bus.channel    <= '0;
    rst_n             <= 1'b0;
    for (int n = 0; n < pqc_pkg::CHANNELS; n++) begin
      lvl_seen[n]  = 1'b0;
      pulses[n]    = '0;
      period_ms[n] = '0;
      edge_at[n]   = '0;
    end
    clock_ms = '0;

    // Directed table: reads after reset, the unused opcode, edges on every lane,
    // a stretched period and a silence that raises the stored period.
    add_row(pqc_pkg::OP_READ,   4'h0, 2'd0, 1, 1'b1, 0, 0);
    add_row(pqc_pkg::OP_READ,   4'h0, 2'd3, 1, 1'b1, 0, 0);
    add_row(OP_UNUSED,          4'hf, 2'd3, 1, 1'b0, 0, 0);
    add_row(pqc_pkg::OP_READ,   4'h0, 2'd1, 1, 1'b1, 0, 0);
    add_row(pqc_pkg::OP_SAMPLE, 4'hf, 2'd0, 1, 1'b0, 0, 0);
    add_row(pqc_pkg::OP_TICK,   4'h0, 2'd0, 2, 1'b0, 0, 0);
    add_row(pqc_pkg::OP_SAMPLE, 4'h0, 2'd0, 1, 1'b0, 0, 0);
    add_row(pqc_pkg::OP_READ,   4'h0, 2'd0, 1, 1'b0, 0, 0);
    add_row(pqc_pkg::OP_SAMPLE, 4'ha, 2'd2, 1, 1'b0, 0, 0);
    add_row(pqc_pkg::OP_TICK,   4'hf, 2'd3, 3, 1'b0, 0, 0);
    add_row(pqc_pkg::OP_SAMPLE, 4'h5, 2'd1, 1, 1'b0, 0, 0);
    add_row(pqc_pkg::OP_SAMPLE, 4'h0, 2'd0, 1, 1'b0, 0, 0);
    add_row(pqc_pkg::OP_TICK,   4'h0, 2'd0, 5, 1'b0, 0, 0);
    add_row(pqc_pkg::OP_READ,   4'h0, 2'd1, 1, 1'b0, 0, 0);
    add_row(pqc_pkg::OP_READ,   4'h0, 2'd2, 1, 1'b0, 0, 0);
    add_row(pqc_pkg::OP_TICK,   4'h0, 2'd0, 9, 1'b0, 0, 0);
    add_row(pqc_pkg::OP_READ,   4'h0, 2'd3, 1, 1'b0, 0, 0);
    add_row(pqc_pkg::OP_SAMPLE, 4'hf, 2'd0, 1, 1'b0, 0, 0);
    add_row(pqc_pkg::OP_TICK,   4'h0, 2'd0, 40, 1'b0, 0, 0);
    add_row(pqc_pkg::OP_SAMPLE, 4'h0, 2'd0, 1, 1'b0, 0, 0);
    add_row(pqc_pkg::OP_READ,   4'h0, 2'd0, 1, 1'b0, 0, 0);
    add_row(pqc_pkg::OP_READ,   4'h0, 2'd0, 1, 1'b0, 0, 0);
    add_row(pqc_pkg::OP_READ,   4'h0, 2'd1, 1, 1'b0, 0, 0);
    add_row(pqc_pkg::OP_READ,   4'h0, 2'd2, 1, 1'b0, 0, 0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the table; rows of more than 100 repetitions run without idling.
    calm      = 1'b0;
    src_idles = 1'b1;
    foreach (plan[i]) begin
      s    = plan[i];
      calm = (s.reps > 100);
      repeat (s.reps) send_word(s.op, s.pins, s.ch, s.typed, s.want);
    end
    calm = 1'b0;

    // Random traffic: mostly samples, ticks in short bursts, frequent reads.
    // Every word of a tick burst counts towards the total.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if ($urandom_range(0, 39) == 0) src_idles = $urandom_range(0, 1);
      calm = (i >= RANDOM_WORDS - CALM_WORDS);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        send_word(pqc_pkg::OP_SAMPLE, 4'($urandom_range(0, 15)),
                  2'($urandom_range(0, 3)), 1'b0, '0);
      end else if (pick < 70) begin
        burst = $urandom_range(1, 20);
        repeat (burst)
          send_word(pqc_pkg::OP_TICK, 4'($urandom_range(0, 15)),
                    2'($urandom_range(0, 3)), 1'b0, '0);
        i = i + burst - 1;
      end else if (pick < 93) begin
        send_word(pqc_pkg::OP_READ, 4'($urandom_range(0, 15)),
                  2'($urandom_range(0, 3)), 1'b0, '0);
      end else begin
        send_word(OP_UNUSED, 4'($urandom_range(0, 15)),
                  2'($urandom_range(0, 3)), 1'b0, '0);
      end
    end
    in_bus.valid <= 1'b0;

    // Drain the outstanding readings, then allow for the output stage.
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("** quad_pulse_counter_with_period_core: PASSED **");
    end else begin
      $display("** quad_pulse_counter_with_period_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/pqc_pkg.sv
hdl/pqc_in_if.sv
hdl/pqc_out_if.sv
hdl/pqc_lane.sv
hdl/pqc_merge.sv
hdl/quad_pulse_counter_with_period_core.sv
tb/quad_pulse_counter_with_period_core_test.sv
